// ===== sv/gasa_pkg.sv =====
// gasa_pkg: shared widths, codes, types and helpers for the glyph atlas shelf allocator
// no dependencies; imported by gasa_place, gasa_div and the top level
package gasa_pkg;

    // field widths
    localparam int DIM_W     = 13;
    localparam int POS_W     = 12;
    localparam int UV_W      = 17;
    localparam int CODE_W    = 8;
    localparam int SLOT_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_BITS = 16;

    // sizing and atlas constants
    localparam int               MAX_GLYPHS_DEF = 256;
    localparam logic [DIM_W-1:0] MAX_TEX_DIM    = 13'd4096;
    localparam logic [DIM_W-1:0] SHELF_MARGIN   = 13'd8;
    localparam logic [DIM_W-1:0] TEX_WIDTH_RST  = 13'd256;
    localparam logic [DIM_W-1:0] TEX_HEIGHT_RST = 13'd128;
    localparam logic [UV_W-1:0]  UV_ONE         = 17'h10000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 2'd1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_PLACED   = 3'd0,
        STS_ZERO     = 3'd1,
        STS_FULL     = 3'd2,
        STS_NO_SPACE = 3'd3,
        STS_CLEARED  = 3'd4
    } status_t;

    // request codes
    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_CLEAR = 1'b1
    } req_t;

    // sequencer states of the top level
    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_CHECK,
        FSM_START,
        FSM_DIV,
        FSM_FINISH
    } fsm_t;

    // which uv fraction the divider is working on
    typedef enum logic [1:0] {
        UV_U_ORIGIN = 2'd0,
        UV_V_ORIGIN = 2'd1,
        UV_U_EXTENT = 2'd2,
        UV_V_EXTENT = 2'd3
    } uv_sel_t;

    // placement outcome handed from the allocator to the sequencer
    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [DIM_W-1:0]   pos_x;
        logic [DIM_W-1:0]   pos_y;
    } place_res_t;

    // texture size as used: zero acts as one, large values clamp
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > MAX_TEX_DIM)
            r = MAX_TEX_DIM;
        return r;
    endfunction

endpackage

// ===== sv/gasa_place.sv =====
// gasa_place: texture size registers, shelf state and the placement decision
// depends on gasa_pkg
module gasa_place import gasa_pkg::*;
#(
    parameter int MAX_GLYPHS = MAX_GLYPHS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 step,
    input  logic                 req_type,
    input  logic [DIM_W-1:0]     glyph_width,
    input  logic [DIM_W-1:0]     glyph_height,
    output place_res_t           res,
    output logic [DIM_W-1:0]     eff_tw,
    output logic [DIM_W-1:0]     eff_th
);

    localparam int              CNT_W   = $clog2(MAX_GLYPHS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_GLYPHS);

    logic [DIM_W-1:0] tw_reg, tw_next;
    logic [DIM_W-1:0] th_reg, th_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [DIM_W-1:0] next_x_reg, next_x_next;
    logic [DIM_W-1:0] top_y_reg, top_y_next;
    logic [DIM_W-1:0] shelf_h_reg, shelf_h_next;
    logic [DIM_W-1:0] free_w_reg, free_w_next;
    logic [DIM_W-1:0] area_top_reg, area_top_next;
    logic [DIM_W-1:0] area_h_reg, area_h_next;
    place_res_t       res_reg, res_next;

    logic             cfg_hit;
    logic [DIM_W-1:0] restart_th;
    logic [DIM_W:0]   width_margin;
    logic             need_shelf;
    logic             no_room;
    logic             zero_size;
    logic             table_full;

    // checks for the incoming glyph
    assign width_margin = {1'b0, glyph_width} + {1'b0, SHELF_MARGIN};
    assign need_shelf   = ({1'b0, free_w_reg} <= width_margin) || (shelf_h_reg < glyph_height);
    assign no_room      = (area_h_reg < glyph_height) || (tw_reg < glyph_width);
    assign zero_size    = (glyph_width == '0) || (glyph_height == '0);
    assign table_full   = (count_reg >= CNT_MAX);

    // a write to the texture width or height register restarts the atlas with the new texture size
    assign cfg_hit    = cfg_we && ((cfg_index == CFG_TEX_WIDTH) || (cfg_index == CFG_TEX_HEIGHT));
    assign restart_th = (cfg_index == CFG_TEX_HEIGHT) ? eff_dim(cfg_data) : th_reg;

    // next atlas state and placement result
    always_comb
    begin
        tw_next       = tw_reg;
        th_next       = th_reg;
        count_next    = count_reg;
        next_x_next   = next_x_reg;
        top_y_next    = top_y_reg;
        shelf_h_next  = shelf_h_reg;
        free_w_next   = free_w_reg;
        area_top_next = area_top_reg;
        area_h_next   = area_h_reg;
        res_next      = res_reg;

        priority if (cfg_hit)
        begin
            if (cfg_index == CFG_TEX_WIDTH)
                tw_next = eff_dim(cfg_data);
            else
                th_next = eff_dim(cfg_data);
            count_next    = '0;
            next_x_next   = '0;
            top_y_next    = '0;
            shelf_h_next  = '0;
            free_w_next   = '0;
            area_top_next = '0;
            area_h_next   = restart_th;
        end
        else if (step)
        begin
            res_next = '{status: STS_PLACED, slot: '0, pos_x: '0, pos_y: '0};
            priority if (req_type == REQ_CLEAR)
            begin
                res_next.status = STS_CLEARED;
                count_next      = '0;
                next_x_next     = '0;
                top_y_next      = '0;
                shelf_h_next    = '0;
                free_w_next     = '0;
                area_top_next   = '0;
                area_h_next     = th_reg;
            end
            else if (zero_size)
                res_next.status = STS_ZERO;
            else if (table_full)
                res_next.status = STS_FULL;
            else if (need_shelf && no_room)
                res_next.status = STS_NO_SPACE;
            else
            begin
                res_next.slot = SLOT_W'(count_reg);
                count_next    = count_reg + CNT_W'(1);
                if (need_shelf)
                begin
                    // open a new shelf under the previous ones
                    res_next.pos_x = '0;
                    res_next.pos_y = area_top_reg;
                    free_w_next    = tw_reg - glyph_width;
                    shelf_h_next   = glyph_height;
                    next_x_next    = glyph_width;
                    top_y_next     = area_top_reg;
                    area_top_next  = area_top_reg + glyph_height;
                    area_h_next    = area_h_reg - glyph_height;
                end
                else
                begin
                    // continue along the current shelf
                    res_next.pos_x = next_x_reg;
                    res_next.pos_y = top_y_reg;
                    free_w_next    = free_w_reg - glyph_width;
                    next_x_next    = next_x_reg + glyph_width;
                end
            end
        end
    end

    // atlas state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_reg       <= TEX_WIDTH_RST;
            th_reg       <= TEX_HEIGHT_RST;
            count_reg    <= '0;
            next_x_reg   <= '0;
            top_y_reg    <= '0;
            shelf_h_reg  <= '0;
            free_w_reg   <= '0;
            area_top_reg <= '0;
            area_h_reg   <= TEX_HEIGHT_RST;
        end
        else
        begin
            tw_reg       <= tw_next;
            th_reg       <= th_next;
            count_reg    <= count_next;
            next_x_reg   <= next_x_next;
            top_y_reg    <= top_y_next;
            shelf_h_reg  <= shelf_h_next;
            free_w_reg   <= free_w_next;
            area_top_reg <= area_top_next;
            area_h_reg   <= area_h_next;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res    = res_reg;
    assign eff_tw = tw_reg;
    assign eff_th = th_reg;

    // glyph table never overfills
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("glyph count beyond table size");

    // free area and used area always add up to the texture height
    a_area_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, area_top_reg} + {1'b0, area_h_reg}) == {1'b0, th_reg})
        else $error("free area out of step with texture height");

endmodule

// ===== sv/gasa_div.sv =====
// gasa_div: bit-serial restoring divider giving a saturated unsigned 1.16 fraction
// depends on gasa_pkg
module gasa_div import gasa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIM_W-1:0]  num,
    input  logic [DIM_W-1:0]  den,
    output logic              done,
    output logic [UV_W-1:0]   quo
);

    localparam int               STEPS = FRAC_BITS + 1;
    localparam int               CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(STEPS - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              first_reg, first_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              sat_reg, sat_next;
    logic [DIM_W:0]    rem_reg, rem_next;
    logic [UV_W-1:0]   quo_reg, quo_next;
    logic [DIM_W-1:0]  den_reg, den_next;

    logic [DIM_W+1:0]  trial;
    logic [DIM_W+1:0]  diff;
    logic              ge;

    // one quotient bit per cycle; the first bit takes the numerator as it is
    assign trial = first_reg ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign diff  = trial - {2'b00, den_reg};
    assign ge    = (trial >= {2'b00, den_reg});

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        first_next = first_reg;
        cnt_next   = cnt_reg;
        sat_next   = sat_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            first_next = 1'b1;
            cnt_next   = '0;
            // numerator of two divisors or more is above one in any case
            sat_next   = ({1'b0, num} >= {den, 1'b0});
            rem_next   = {1'b0, num};
            quo_next   = '0;
            den_next   = den;
        end
        else if (busy_reg)
        begin
            first_next = 1'b0;
            rem_next   = ge ? diff[DIM_W:0] : trial[DIM_W:0];
            quo_next   = {quo_reg[UV_W-2:0], ge};
            cnt_next   = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            first_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            first_reg <= first_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge clk)
    begin
        sat_reg <= sat_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    // saturate at one
    assign done = done_reg;
    assign quo  = (sat_reg || (quo_reg > UV_ONE)) ? UV_ONE : quo_reg;

    // a new division only starts on an idle unit
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    // done follows the last step of a running division
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a division");

    // a finished quotient never exceeds one
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> quo <= UV_ONE)
        else $error("quotient above one");

endmodule

// ===== sv/glyph_atlas_shelf_allocator.sv =====
// glyph_atlas_shelf_allocator: top level, sequencer, divider sharing and result register
// depends on gasa_pkg, gasa_place and gasa_div
//
//   channel   direction  handshake               word
//   in        input      in_valid / in_stall     req_type, glyph_code, glyph_width, glyph_height
//   out       output     out_valid / out_stall   status, slot, code_out, pos_x, pos_y, uv fields
//   cfg       input      cfg_we                  cfg_index, cfg_data
//
// one request at a time: a placed glyph runs from acceptance through the check
// state and four 17-step passes of the shared bit-serial divider, each opened by
// a start state, then the finish state (held while the output stalls) and idle
// a refused request or a clear goes from the check state straight to finish
// reset clears the atlas and sets the texture to 256 by 128; no clearing pass is needed
// a stalled result sits in the output register while the next request is already taken
module glyph_atlas_shelf_allocator import gasa_pkg::*;
#(
    parameter int MAX_GLYPHS = MAX_GLYPHS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 req_type,
    input  logic [CODE_W-1:0]    glyph_code,
    input  logic [DIM_W-1:0]     glyph_width,
    input  logic [DIM_W-1:0]     glyph_height,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATUS_W-1:0]  status,
    output logic [SLOT_W-1:0]    slot,
    output logic [CODE_W-1:0]    code_out,
    output logic [POS_W-1:0]     pos_x,
    output logic [POS_W-1:0]     pos_y,
    output logic [UV_W-1:0]      u_origin,
    output logic [UV_W-1:0]      v_origin,
    output logic [UV_W-1:0]      u_extent,
    output logic [UV_W-1:0]      v_extent
);

    fsm_t             state_reg, state_next;
    uv_sel_t          sel_reg, sel_next;
    logic [CODE_W-1:0] code_reg;
    logic [DIM_W-1:0] w_reg;
    logic [DIM_W-1:0] h_reg;
    logic [UV_W-1:0]  u_org_reg, v_org_reg, u_ext_reg, v_ext_reg;

    logic              out_valid_reg, out_valid_next;
    status_t           status_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CODE_W-1:0] code_out_reg;
    logic [POS_W-1:0]  pos_x_reg, pos_y_reg;
    logic [UV_W-1:0]   u_origin_reg, v_origin_reg, u_extent_reg, v_extent_reg;

    logic             accept;
    logic             out_free;
    logic             out_load;
    logic             div_start;
    logic             div_done;
    logic [UV_W-1:0]  div_quo;
    logic [DIM_W-1:0] div_num, div_den;
    logic             placed;
    place_res_t       res;
    logic [DIM_W-1:0] eff_tw, eff_th;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != FSM_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign placed   = (res.status == STS_PLACED);

    // atlas state and placement
    gasa_place #(
        .MAX_GLYPHS (MAX_GLYPHS)
    ) u_place (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .step         (accept),
        .req_type     (req_type),
        .glyph_width  (glyph_width),
        .glyph_height (glyph_height),
        .res          (res),
        .eff_tw       (eff_tw),
        .eff_th       (eff_th)
    );

    // divider operands for the fraction in hand
    always_comb
    begin
        unique case (sel_reg)
            UV_U_ORIGIN:
            begin
                div_num = res.pos_x;
                div_den = eff_tw;
            end
            UV_V_ORIGIN:
            begin
                div_num = res.pos_y;
                div_den = eff_th;
            end
            UV_U_EXTENT:
            begin
                div_num = w_reg;
                div_den = eff_tw;
            end
            default:
            begin
                div_num = h_reg;
                div_den = eff_th;
            end
        endcase
    end

    gasa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
                if (accept)
                    state_next = FSM_CHECK;
            FSM_CHECK:
                state_next = placed ? FSM_START : FSM_FINISH;
            FSM_START:
                state_next = FSM_DIV;
            FSM_DIV:
                if (div_done)
                    state_next = (sel_reg == UV_V_EXTENT) ? FSM_FINISH : FSM_START;
            FSM_FINISH:
                if (out_free)
                    state_next = FSM_IDLE;
            default:
                state_next = FSM_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        div_start = 1'b0;
        out_load  = 1'b0;
        sel_next  = sel_reg;
        unique case (state_reg)
            FSM_CHECK:
                sel_next = UV_U_ORIGIN;
            FSM_START:
                div_start = 1'b1;
            FSM_DIV:
                if (div_done)
                    sel_next = uv_sel_t'(sel_reg + 2'd1);
            FSM_FINISH:
                out_load = out_free;
            default:
                sel_next = sel_reg;
        endcase
    end

    // output word valid
    always_comb
    begin
        priority if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            sel_reg       <= UV_U_ORIGIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request capture and quotient collection
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg <= glyph_code;
            w_reg    <= glyph_width;
            h_reg    <= glyph_height;
        end
        if ((state_reg == FSM_DIV) && div_done)
        begin
            unique case (sel_reg)
                UV_U_ORIGIN: u_org_reg <= div_quo;
                UV_V_ORIGIN: v_org_reg <= div_quo;
                UV_U_EXTENT: u_ext_reg <= div_quo;
                default:     v_ext_reg <= div_quo;
            endcase
        end
    end

    // output register; refused and clear results carry zeros
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg   <= res.status;
            slot_reg     <= res.slot;
            code_out_reg <= placed ? code_reg : '0;
            pos_x_reg    <= res.pos_x[POS_W-1:0];
            pos_y_reg    <= res.pos_y[POS_W-1:0];
            u_origin_reg <= placed ? u_org_reg : '0;
            v_origin_reg <= placed ? v_org_reg : '0;
            u_extent_reg <= placed ? u_ext_reg : '0;
            v_extent_reg <= placed ? v_ext_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;
    assign code_out  = code_out_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign u_origin  = u_origin_reg;
    assign v_origin  = v_origin_reg;
    assign u_extent  = u_extent_reg;
    assign v_extent  = v_extent_reg;

    // an accepted request always moves on to the placement check
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == FSM_CHECK)
        else $error("accepted request not taken to check");

    // a placed glyph always has a nonzero extent in both directions
    a_placed_extent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STS_PLACED)) |-> (u_extent != '0) && (v_extent != '0))
        else $error("placed glyph with zero uv extent");

    // the divider only reports back while the sequencer waits for it
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == FSM_DIV)
        else $error("divider result outside the divide state");

endmodule
